// ===== rtl/gso_pkg.sv =====
`default_nettype none
package gso_pkg;

  // threshold register
  localparam int THR_W = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd10737;

  // APB address space: one 32-bit register
  localparam int ADDR_W = 3;
  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0
  } reg_idx_t;

  // rounded dot product / cross product width
  localparam int RW = 35;

  // status leaving a normalise pipe
  typedef struct packed {
    logic valid;
    logic zero;
  } gso_nstat_t;

  // magnitude of a 64-bit two's complement value
  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // round from scale 2^30 down, half away from zero
  function automatic logic signed [RW-1:0] rnd30(input logic signed [63:0] x);
    logic [63:0] m;
    logic [33:0] r;
    m = mag64(x);
    r = 34'((m + (64'd1 << 29)) >> 30);
    return x[63] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  // residual magnitude brought to Q2.30
  function automatic logic [47:0] deg_e(input logic signed [63:0] x);
    return 48'(mag64(x) >> 16);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gso_norm.sv =====
`default_nettype none
module gso_norm import gso_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [63:0]      x [3],
  input  logic [TAG_W-1:0]        tag_in,
  output gso_nstat_t              stat,
  output logic signed [31:0]      y [3],
  output logic [TAG_W-1:0]        tag_out
);

  localparam int SQ_N = 32;
  localparam int DV_N = 31;
  localparam int L    = 6 + SQ_N + 1 + DV_N + 1;
  localparam int DLW  = TAG_W + 4;

  // side band: zero flag, signs and tag ride alongside the arithmetic
  logic [DLW-1:0] dl [0:L];
  logic           vl [1:L];

  logic [63:0]    n1_m [3];
  logic [63:0]    n2_m [3];
  logic [63:0]    n2_mx;
  logic [63:0]    n3_m [3];
  logic [7:0]     n3_nz;
  logic [2:0]     n3_pos [8];
  logic [63:0]    n4_m [3];
  logic [5:0]     n4_p;
  logic [29:0]    n5_mn [3];
  logic [59:0]    n6_sq [3];
  logic [29:0]    n6_mn [3];
  logic [63:0]    sq_s [1:SQ_N];
  logic [63:0]    sq_r [1:SQ_N];
  logic [29:0]    sq_mn [1:SQ_N][3];
  logic [61:0]    dv_p [0:DV_N][3];
  logic [30:0]    dv_d [0:DV_N];
  logic [30:0]    dv_q [0:DV_N][3];

  logic [63:0]    mx_c;
  logic [7:0]     nz_c;
  logic [2:0]     pos_c [8];
  logic [5:0]     p_c;

  assign dl[0] = {(x[0] == 64'sd0 && x[1] == 64'sd0 && x[2] == 64'sd0),
                  x[0][63], x[1][63], x[2][63], tag_in};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= L; k++) vl[k] <= 1'b0;
    end else if (en) begin
      vl[1] <= in_valid;
      for (int k = 2; k <= L; k++) vl[k] <= vl[k-1];
    end
  end

  // largest magnitude and per-byte leading one
  always_comb begin
    mx_c = n1_m[0];
    if (n1_m[1] > mx_c) mx_c = n1_m[1];
    if (n1_m[2] > mx_c) mx_c = n1_m[2];
    for (int c = 0; c < 8; c++) begin
      nz_c[c]  = |n2_mx[8*c +: 8];
      pos_c[c] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (n2_mx[8*c + b]) pos_c[c] = 3'(b);
      end
    end
    p_c = 6'd0;
    for (int c = 0; c < 8; c++) begin
      if (n3_nz[c]) p_c = {3'(c), n3_pos[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[1:L] <= dl[0:L-1];
      for (int i = 0; i < 3; i++) begin
        n1_m[i] <= mag64(x[i]);
        n2_m[i] <= n1_m[i];
        n3_m[i] <= n2_m[i];
        n4_m[i] <= n3_m[i];
        // bring the leading one of the largest to bit 29
        if (n4_p >= 6'd29) n5_mn[i] <= 30'(n4_m[i] >> (n4_p - 6'd29));
        else               n5_mn[i] <= 30'(n4_m[i] << (6'd29 - n4_p));
        n6_sq[i] <= n5_mn[i] * n5_mn[i];
        n6_mn[i] <= n5_mn[i];
      end
      n2_mx  <= mx_c;
      n3_nz  <= nz_c;
      n3_pos <= pos_c;
      n4_p   <= p_c;

      // square root, one result bit per stage
      sq_s[1]  <= 64'(n6_sq[0]) + 64'(n6_sq[1]) + 64'(n6_sq[2]);
      sq_r[1]  <= 64'd0;
      sq_mn[1] <= n6_mn;
      for (int k = 1; k < SQ_N; k++) begin
        if (sq_s[k] >= sq_r[k] + (64'd1 << (62 - 2*k))) begin
          sq_s[k+1] <= sq_s[k] - (sq_r[k] + (64'd1 << (62 - 2*k)));
          sq_r[k+1] <= (sq_r[k] >> 1) + (64'd1 << (62 - 2*k));
        end else begin
          sq_s[k+1] <= sq_s[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
        sq_mn[k+1] <= sq_mn[k];
      end

      // divider set-up: (m * 2^30 + r/2) / r
      dv_d[0] <= 31'(sq_r[SQ_N]);
      for (int i = 0; i < 3; i++) begin
        dv_p[0][i] <= {2'b0, sq_mn[SQ_N][i], 30'd0} + 62'(sq_r[SQ_N] >> 1);
        dv_q[0][i] <= 31'd0;
      end

      // restoring division, quotient bits from the top
      for (int k = 0; k < DV_N; k++) begin
        dv_d[k+1] <= dv_d[k];
        for (int i = 0; i < 3; i++) begin
          if (dv_p[k][i] >= (62'(dv_d[k]) << (30 - k))) begin
            dv_p[k+1][i] <= dv_p[k][i] - (62'(dv_d[k]) << (30 - k));
            dv_q[k+1][i] <= {dv_q[k][i][29:0], 1'b1};
          end else begin
            dv_p[k+1][i] <= dv_p[k][i];
            dv_q[k+1][i] <= {dv_q[k][i][29:0], 1'b0};
          end
        end
      end

      // signs back on
      for (int i = 0; i < 3; i++) begin
        if (dl[L-1][TAG_W+3])       y[i] <= 32'sd0;
        else if (dl[L-1][TAG_W+2-i]) y[i] <= -$signed(32'(dv_q[DV_N][i]));
        else                         y[i] <= $signed(32'(dv_q[DV_N][i]));
      end
    end
  end

  assign stat.valid = vl[L];
  assign stat.zero  = dl[L][TAG_W+3];
  assign tag_out    = dl[L][TAG_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/gram_schmidt_orthonormalize_3d.sv =====
`default_nettype none
// Throughput: one word per cycle; every stage advances together and a
// stalled output holds the whole pipe. The three normalise pipes (square
// root and divider, one result bit per stage) set the depth.
// Reset (synchronous, rst high): all valid bits cleared, threshold 10737.
module gram_schmidt_orthonormalize_3d import gso_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         vec_valid,
  output logic                         vec_ready,
  input  logic signed [DATA_WIDTH-1:0] a_x,
  input  logic signed [DATA_WIDTH-1:0] a_y,
  input  logic signed [DATA_WIDTH-1:0] a_z,
  input  logic signed [DATA_WIDTH-1:0] b_x,
  input  logic signed [DATA_WIDTH-1:0] b_y,
  input  logic signed [DATA_WIDTH-1:0] b_z,
  input  logic signed [DATA_WIDTH-1:0] c_x,
  input  logic signed [DATA_WIDTH-1:0] c_y,
  input  logic signed [DATA_WIDTH-1:0] c_z,
  output logic                         basis_valid,
  input  logic                         basis_ready,
  output logic signed [31:0]           u_x,
  output logic signed [31:0]           u_y,
  output logic signed [31:0]           u_z,
  output logic signed [31:0]           v_x,
  output logic signed [31:0]           v_y,
  output logic signed [31:0]           v_z,
  output logic signed [31:0]           w_x,
  output logic signed [31:0]           w_y,
  output logic signed [31:0]           w_z,
  output logic                         first_zero,
  output logic                         second_replaced,
  output logic                         third_replaced,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 32 + DW;
  localparam int XW = 32 + RW;
  localparam int TA = 6 * DW;
  localparam int TV = 3*32 + 3*64 + 3*RW + 2;
  localparam int TW = 3*32 * 3 + 3;

  logic            adv;
  logic [THR_W-1:0] thr;
  logic             cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr && reg_idx_t'(paddr[ADDR_W-1:2]) == REG_THRESHOLD) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_THRESHOLD: prdata = {1'b0, thr};
      default:       prdata = 32'd0;
    endcase
  end

  // whole pipe moves unless the output word is stuck
  assign adv       = !basis_valid || basis_ready;
  assign vec_ready = adv;

  // ---------------- first vector ----------------
  logic signed [63:0]  xa [3];
  logic [TA-1:0]       ta_in, ta_o;
  gso_nstat_t          sa;
  logic signed [31:0]  ua [3];
  logic signed [DW-1:0] tb [3];
  logic signed [DW-1:0] tc [3];

  assign xa[0] = 64'(a_x);
  assign xa[1] = 64'(a_y);
  assign xa[2] = 64'(a_z);
  assign ta_in = {b_x, b_y, b_z, c_x, c_y, c_z};

  gso_norm #(.TAG_W(TA)) u_norm_a (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vec_valid),
    .x(xa), .tag_in(ta_in), .stat(sa), .y(ua), .tag_out(ta_o)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tb[i] = ta_o[TA-1-DW*i -: DW];
      tc[i] = ta_o[TA-1-DW*(3+i) -: DW];
    end
  end

  // ---------------- second vector residual ----------------
  logic                  p_vld [1:8];
  logic signed [31:0]    p1_u [3], p2_u [3], p3_u [3], p4_u [3], p5_u [3];
  logic signed [31:0]    p6_u [3], p7_u [3], p8_u [3];
  logic signed [DW-1:0]  p1_b [3], p2_b [3], p3_b [3], p4_b [3];
  logic signed [DW-1:0]  p1_c [3], p2_c [3], p3_c [3], p4_c [3];
  logic signed [PW-1:0]  p1_pb [3], p1_pc [3];
  logic signed [63:0]    p2_db, p2_dc;
  logic signed [RW-1:0]  p3_db, p3_dc;
  logic signed [XW-1:0]  p4_pb [3], p4_pc [3];
  logic signed [63:0]    p5_rb [3], p5_rc [3];
  logic signed [63:0]    p6_rb [3], p6_rc [3], p6_fb [3];
  logic [30:0]           p6_e [3];
  logic                  p6_big, p6_rbz;
  logic signed [RW-1:0]  p6_r16 [3], p7_r16 [3], p8_r16 [3];
  logic signed [63:0]    p7_rb [3], p7_rc [3], p7_fb [3], p8_rc [3];
  logic [61:0]           p7_sq [3];
  logic                  p7_big, p7_rbz;
  logic signed [63:0]    p8_nv [3];
  logic                  p8_sr;
  logic                  p1_fz, p2_fz, p3_fz, p4_fz, p5_fz, p6_fz, p7_fz, p8_fz;
  logic [47:0]           eb_c [3];
  logic [63:0]           sb_c;
  logic                  degb_c, srb_c;

  always_comb begin
    for (int i = 0; i < 3; i++) eb_c[i] = deg_e(p5_rb[i]);
    sb_c   = 64'(p7_sq[0]) + 64'(p7_sq[1]) + 64'(p7_sq[2]);
    degb_c = !p7_big && ((sb_c >> 30) < 64'(thr));
    srb_c  = degb_c || p7_rbz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 8; k++) p_vld[k] <= 1'b0;
    end else if (adv) begin
      p_vld[1] <= sa.valid;
      for (int k = 2; k <= 8; k++) p_vld[k] <= p_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products with u
      for (int i = 0; i < 3; i++) begin
        p1_u[i]  <= ua[i];
        p1_b[i]  <= tb[i];
        p1_c[i]  <= tc[i];
        p1_pb[i] <= ua[i] * tb[i];
        p1_pc[i] <= ua[i] * tc[i];
      end
      p1_fz <= sa.zero;
      // dot sums
      p2_db <= 64'(p1_pb[0] + p1_pb[1] + p1_pb[2]);
      p2_dc <= 64'(p1_pc[0] + p1_pc[1] + p1_pc[2]);
      p2_u <= p1_u; p2_b <= p1_b; p2_c <= p1_c; p2_fz <= p1_fz;
      // rounded dots
      p3_db <= rnd30(p2_db);
      p3_dc <= rnd30(p2_dc);
      p3_u <= p2_u; p3_b <= p2_b; p3_c <= p2_c; p3_fz <= p2_fz;
      // projections
      for (int i = 0; i < 3; i++) begin
        p4_pb[i] <= p3_u[i] * p3_db;
        p4_pc[i] <= p3_u[i] * p3_dc;
      end
      p4_u <= p3_u; p4_b <= p3_b; p4_c <= p3_c; p4_fz <= p3_fz;
      // residuals at scale 2^46, wrapping at 64 bits
      for (int i = 0; i < 3; i++) begin
        p5_rb[i] <= (64'(p4_b[i]) <<< 30) - 64'(p4_pb[i]);
        p5_rc[i] <= (64'(p4_c[i]) <<< 30) - 64'(p4_pc[i]);
      end
      p5_u <= p4_u; p5_fz <= p4_fz;
      // degeneracy terms, rounded c residual, fallback direction
      for (int i = 0; i < 3; i++) begin
        p6_e[i]   <= eb_c[i][30:0];
        p6_r16[i] <= rnd30(p5_rc[i]);
      end
      p6_big <= (|eb_c[0][47:31]) || (|eb_c[1][47:31]) || (|eb_c[2][47:31]);
      p6_rbz <= p5_rb[0] == 64'sd0 && p5_rb[1] == 64'sd0 && p5_rb[2] == 64'sd0;
      if (mag64(64'(p5_u[0])) > mag64(64'(p5_u[1]))) begin
        p6_fb[0] <= -64'(p5_u[2]);
        p6_fb[1] <= 64'sd0;
        p6_fb[2] <= 64'(p5_u[0]);
      end else begin
        p6_fb[0] <= 64'sd0;
        p6_fb[1] <= 64'(p5_u[2]);
        p6_fb[2] <= -64'(p5_u[1]);
      end
      p6_rb <= p5_rb; p6_rc <= p5_rc; p6_u <= p5_u; p6_fz <= p5_fz;
      // squares
      for (int i = 0; i < 3; i++) p7_sq[i] <= p6_e[i] * p6_e[i];
      p7_big <= p6_big; p7_rbz <= p6_rbz;
      p7_rb <= p6_rb; p7_rc <= p6_rc; p7_fb <= p6_fb; p7_r16 <= p6_r16;
      p7_u <= p6_u; p7_fz <= p6_fz;
      // threshold and selection
      p8_sr <= srb_c;
      p8_nv <= srb_c ? p7_fb : p7_rb;
      p8_rc <= p7_rc; p8_r16 <= p7_r16; p8_u <= p7_u; p8_fz <= p7_fz;
    end
  end

  // ---------------- second basis vector ----------------
  logic [TV-1:0]       tv_in, tv_o;
  gso_nstat_t          sv;
  logic signed [31:0]  vv [3];
  logic signed [31:0]  nu [3];
  logic signed [63:0]  nrc [3];
  logic signed [RW-1:0] nr16 [3];

  assign tv_in = {p8_u[0], p8_u[1], p8_u[2], p8_rc[0], p8_rc[1], p8_rc[2],
                  p8_r16[0], p8_r16[1], p8_r16[2], p8_sr, p8_fz};

  gso_norm #(.TAG_W(TV)) u_norm_v (
    .clk(clk), .rst(rst), .en(adv), .in_valid(p_vld[8]),
    .x(p8_nv), .tag_in(tv_in), .stat(sv), .y(vv), .tag_out(tv_o)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nu[i]   = tv_o[TV-1-32*i -: 32];
      nrc[i]  = tv_o[TV-97-64*i -: 64];
      nr16[i] = tv_o[TV-289-RW*i -: RW];
    end
  end

  // ---------------- third vector residual ----------------
  logic                  q_vld [1:8];
  logic signed [31:0]    q1_u [3], q2_u [3], q3_u [3], q4_u [3], q5_u [3];
  logic signed [31:0]    q6_u [3], q7_u [3], q8_u [3];
  logic signed [31:0]    q1_v [3], q2_v [3], q3_v [3], q4_v [3], q5_v [3];
  logic signed [31:0]    q6_v [3], q7_v [3], q8_v [3];
  logic signed [63:0]    q1_rc [3], q2_rc [3], q3_rc [3], q4_rc [3];
  logic signed [XW-1:0]  q1_pv [3], q4_p [3];
  logic signed [63:0]    q1_x [6];
  logic signed [63:0]    q2_d, q2_cr [3];
  logic signed [RW-1:0]  q3_d;
  logic signed [31:0]    q3_wc [3], q4_wc [3], q5_wc [3], q6_wc [3], q7_wc [3], q8_wc [3];
  logic signed [63:0]    q5_r2 [3], q6_r2 [3], q7_r2 [3], q8_r2 [3];
  logic [30:0]           q6_e [3];
  logic                  q6_big, q6_rz, q7_big, q7_rz, q8_tr;
  logic [61:0]           q7_sq [3];
  logic                  q1_sr, q2_sr, q3_sr, q4_sr, q5_sr, q6_sr, q7_sr, q8_sr;
  logic                  q1_fz, q2_fz, q3_fz, q4_fz, q5_fz, q6_fz, q7_fz, q8_fz;
  logic [47:0]           ec_c [3];
  logic [63:0]           sc_c;

  always_comb begin
    for (int i = 0; i < 3; i++) ec_c[i] = deg_e(q5_r2[i]);
    sc_c = 64'(q7_sq[0]) + 64'(q7_sq[1]) + 64'(q7_sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 8; k++) q_vld[k] <= 1'b0;
    end else if (adv) begin
      q_vld[1] <= sv.valid;
      for (int k = 2; k <= 8; k++) q_vld[k] <= q_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // v dot rc16, cross product terms
      for (int i = 0; i < 3; i++) q1_pv[i] <= vv[i] * nr16[i];
      q1_x[0] <= nu[1] * vv[2];
      q1_x[1] <= nu[2] * vv[1];
      q1_x[2] <= nu[2] * vv[0];
      q1_x[3] <= nu[0] * vv[2];
      q1_x[4] <= nu[0] * vv[1];
      q1_x[5] <= nu[1] * vv[0];
      q1_u <= nu; q1_v <= vv; q1_rc <= nrc;
      q1_sr <= tv_o[1]; q1_fz <= tv_o[0];
      // sums
      q2_d     <= 64'(q1_pv[0] + q1_pv[1] + q1_pv[2]);
      q2_cr[0] <= q1_x[0] - q1_x[1];
      q2_cr[1] <= q1_x[2] - q1_x[3];
      q2_cr[2] <= q1_x[4] - q1_x[5];
      q2_u <= q1_u; q2_v <= q1_v; q2_rc <= q1_rc; q2_sr <= q1_sr; q2_fz <= q1_fz;
      // rounding
      q3_d <= rnd30(q2_d);
      for (int i = 0; i < 3; i++) q3_wc[i] <= 32'(rnd30(q2_cr[i]));
      q3_u <= q2_u; q3_v <= q2_v; q3_rc <= q2_rc; q3_sr <= q2_sr; q3_fz <= q2_fz;
      // projection on v
      for (int i = 0; i < 3; i++) q4_p[i] <= q3_v[i] * q3_d;
      q4_u <= q3_u; q4_v <= q3_v; q4_rc <= q3_rc; q4_wc <= q3_wc;
      q4_sr <= q3_sr; q4_fz <= q3_fz;
      // second residual
      for (int i = 0; i < 3; i++) q5_r2[i] <= q4_rc[i] - 64'(q4_p[i]);
      q5_u <= q4_u; q5_v <= q4_v; q5_wc <= q4_wc; q5_sr <= q4_sr; q5_fz <= q4_fz;
      // degeneracy terms
      for (int i = 0; i < 3; i++) q6_e[i] <= ec_c[i][30:0];
      q6_big <= (|ec_c[0][47:31]) || (|ec_c[1][47:31]) || (|ec_c[2][47:31]);
      q6_rz  <= q5_r2[0] == 64'sd0 && q5_r2[1] == 64'sd0 && q5_r2[2] == 64'sd0;
      q6_r2 <= q5_r2; q6_u <= q5_u; q6_v <= q5_v; q6_wc <= q5_wc;
      q6_sr <= q5_sr; q6_fz <= q5_fz;
      // squares
      for (int i = 0; i < 3; i++) q7_sq[i] <= q6_e[i] * q6_e[i];
      q7_big <= q6_big; q7_rz <= q6_rz;
      q7_r2 <= q6_r2; q7_u <= q6_u; q7_v <= q6_v; q7_wc <= q6_wc;
      q7_sr <= q6_sr; q7_fz <= q6_fz;
      // threshold
      q8_tr <= (!q7_big && ((sc_c >> 30) < 64'(thr))) || q7_rz;
      q8_r2 <= q7_r2; q8_u <= q7_u; q8_v <= q7_v; q8_wc <= q7_wc;
      q8_sr <= q7_sr; q8_fz <= q7_fz;
    end
  end

  // ---------------- third basis vector ----------------
  logic [TW-1:0]       tw_in, tw_o;
  gso_nstat_t          sw;
  logic signed [31:0]  wn [3];

  assign tw_in = {q8_u[0], q8_u[1], q8_u[2], q8_v[0], q8_v[1], q8_v[2],
                  q8_wc[0], q8_wc[1], q8_wc[2], q8_sr, q8_tr, q8_fz};

  gso_norm #(.TAG_W(TW)) u_norm_w (
    .clk(clk), .rst(rst), .en(adv), .in_valid(q_vld[8]),
    .x(q8_r2), .tag_in(tw_in), .stat(sw), .y(wn), .tag_out(tw_o)
  );

  // ---------------- output word ----------------
  logic signed [31:0] f_u [3], f_v [3], f_w [3];
  logic               f_fz, f_sr, f_tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_valid <= 1'b0;
    end else if (adv) begin
      basis_valid <= sw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_fz <= tw_o[0];
      f_sr <= tw_o[0] ? 1'b0 : tw_o[2];
      f_tr <= tw_o[0] ? 1'b0 : tw_o[1];
      for (int i = 0; i < 3; i++) begin
        if (tw_o[0]) begin
          f_u[i] <= 32'sd0;
          f_v[i] <= 32'sd0;
          f_w[i] <= 32'sd0;
        end else begin
          f_u[i] <= tw_o[TW-1-32*i -: 32];
          f_v[i] <= tw_o[TW-97-32*i -: 32];
          f_w[i] <= tw_o[1] ? $signed(tw_o[TW-193-32*i -: 32]) : wn[i];
        end
      end
    end
  end

  assign u_x = f_u[0];
  assign u_y = f_u[1];
  assign u_z = f_u[2];
  assign v_x = f_v[0];
  assign v_y = f_v[1];
  assign v_z = f_v[2];
  assign w_x = f_w[0];
  assign w_y = f_w[1];
  assign w_z = f_w[2];
  assign first_zero      = f_fz;
  assign second_replaced = f_sr;
  assign third_replaced  = f_tr;

`ifndef NO_ASSERTIONS
  // zero first vector gives an all-zero word with no replacement flags
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    basis_valid && first_zero |-> !second_replaced && !third_replaced &&
    u_x == 32'sd0 && v_y == 32'sd0 && w_z == 32'sd0)
    else $error("zero first vector word not cleared");

  // a normalised first vector stays within unit range
  a_u_range: assert property (@(posedge clk) disable iff (rst)
    basis_valid && !first_zero |-> u_x <= 32'sd1073741824 && u_x >= -32'sd1073741824)
    else $error("u_x outside unit range");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !basis_valid)
    else $error("output valid after reset");

  // threshold write lands
  a_thr_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && reg_idx_t'(paddr[ADDR_W-1:2]) == REG_THRESHOLD |=>
    thr == $past(pwdata[THR_W-1:0]))
    else $error("threshold write lost");
`endif

endmodule
`default_nettype wire

// ===== tb/gso_basis_checker.sv =====
module gso_basis_checker import gso_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               vec_valid,
  input  logic               vec_ready,
  input  logic [8:0][31:0]   vec_word,
  input  logic               basis_valid,
  input  logic               basis_ready,
  input  logic [8:0][31:0]   basis_vecs,
  input  logic               first_zero,
  input  logic               second_replaced,
  input  logic               third_replaced,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t [3];

  typedef struct {
    logic [8:0][31:0] vecs;
    logic             fz;
    logic             sr;
    logic             tr;
  } basis_t;

  logic [THR_W-1:0] thr_q;
  basis_t           basis_q [$];

  function automatic logic [63:0] mag_of(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // round half away from zero, dropping k bits
  function automatic longint round_k(longint x, int k);
    logic [63:0] r;
    r = (mag_of(x) + (64'd1 << (k - 1))) >> k;
    return x < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // unit vector in Q2.30; returns 0 for a zero vector
  function automatic bit unit_vec(input vec3_t vin, output vec3_t vout);
    logic [63:0] m [3];
    logic [63:0] mx, s, r, q;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag_of(vin[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) vout[i] = 0;
      return 0;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (r >> 1)) / r;
      vout[i] = vin[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint dot30(input vec3_t p, input vec3_t x);
    return round_k(p[0] * x[0] + p[1] * x[1] + p[2] * x[2], 30);
  endfunction

  function automatic bit is_flat(input vec3_t r, input logic [THR_W-1:0] thr);
    logic [63:0] e [3];
    logic [63:0] sum;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      e[i] = mag_of(r[i]) >> 16;
      if (e[i] >= (64'd1 << 31)) return 0;
    end
    for (int i = 0; i < 3; i++) sum = sum + e[i] * e[i];
    return (sum >> 30) < {33'd0, thr};
  endfunction

  function automatic basis_t predict_basis(logic [8:0][31:0] wd, logic [THR_W-1:0] thr);
    vec3_t a, b, c, u, v, w, rb, rc, rc16, rc2, e;
    longint d;
    basis_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(wd[i]));
      b[i] = longint'($signed(wd[3 + i]));
      c[i] = longint'($signed(wd[6 + i]));
      u[i] = 0;
      v[i] = 0;
      w[i] = 0;
    end
    res.fz = (a[0] == 0 && a[1] == 0 && a[2] == 0);
    res.sr = 0;
    res.tr = 0;
    if (!res.fz) begin
      void'(unit_vec(a, u));
      // second vector: strip u, fall back to u x axis
      d = dot30(u, b);
      for (int i = 0; i < 3; i++) rb[i] = b[i] * (longint'(1) << 30) - u[i] * d;
      if (is_flat(rb, thr) || !unit_vec(rb, v)) begin
        res.sr = 1;
        if (mag_of(u[0]) > mag_of(u[1])) begin
          e[0] = -u[2]; e[1] = 0; e[2] = u[0];
        end else begin
          e[0] = 0; e[1] = u[2]; e[2] = -u[1];
        end
        void'(unit_vec(e, v));
      end
      // third vector: strip u then v, fall back to u x v
      d = dot30(u, c);
      for (int i = 0; i < 3; i++) begin
        rc[i] = c[i] * (longint'(1) << 30) - u[i] * d;
        rc16[i] = round_k(rc[i], 30);
      end
      d = dot30(v, rc16);
      for (int i = 0; i < 3; i++) rc2[i] = rc[i] - v[i] * d;
      if (is_flat(rc2, thr) || !unit_vec(rc2, w)) begin
        res.tr = 1;
        w[0] = round_k(u[1] * v[2] - u[2] * v[1], 30);
        w[1] = round_k(u[2] * v[0] - u[0] * v[2], 30);
        w[2] = round_k(u[0] * v[1] - u[1] * v[0], 30);
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.vecs[i] = u[i][31:0];
      res.vecs[3 + i] = v[i][31:0];
      res.vecs[6 + i] = w[i][31:0];
    end
    return res;
  endfunction

  assign pending = basis_q.size();

  initial fails = 0;

  always @(posedge clk) begin
    basis_t exp_b;
    if (rst) begin
      thr_q <= THR_RESET;
      basis_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_THRESHOLD)
        thr_q <= pwdata[THR_W-1:0];
      // accepted input word
      if (vec_valid && vec_ready)
        basis_q.push_back(predict_basis(vec_word, thr_q));
      // accepted basis word
      if (basis_valid && basis_ready) begin
        if (basis_q.size() == 0) begin
          $display("%0t: unexpected basis word %h", $time, basis_vecs);
          fails++;
        end else begin
          exp_b = basis_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (basis_vecs[i] !== exp_b.vecs[i]) begin
              $display("%0t: component %0d expected %h actual %h", $time, i,
                       exp_b.vecs[i], basis_vecs[i]);
              fails++;
            end
          if (first_zero !== exp_b.fz || second_replaced !== exp_b.sr ||
              third_replaced !== exp_b.tr) begin
            $display("%0t: flags expected %b%b%b actual %b%b%b", $time, exp_b.fz,
                     exp_b.sr, exp_b.tr, first_zero, second_replaced, third_replaced);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_gram_schmidt_orthonormalize_3d.sv =====
module tb_gram_schmidt_orthonormalize_3d import gso_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] ADDR_THR   = {REG_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE = 3'd4;
  localparam logic [31:0]       ONE        = 32'h0001_0000;

  logic clk = 0;
  logic rst = 1;
  logic vec_valid = 0;
  logic vec_ready;
  logic [8:0][31:0] vec_word = '0;
  logic basis_valid;
  logic basis_ready = 0;
  logic [8:0][31:0] basis_vecs;
  logic first_zero, second_replaced, third_replaced;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fails, pending;

  bit quiet = 0;
  bit hold_req = 0;

  gram_schmidt_orthonormalize_3d dut (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_ready(vec_ready),
    .a_x(vec_word[0]), .a_y(vec_word[1]), .a_z(vec_word[2]),
    .b_x(vec_word[3]), .b_y(vec_word[4]), .b_z(vec_word[5]),
    .c_x(vec_word[6]), .c_y(vec_word[7]), .c_z(vec_word[8]),
    .basis_valid(basis_valid), .basis_ready(basis_ready),
    .u_x(basis_vecs[0]), .u_y(basis_vecs[1]), .u_z(basis_vecs[2]),
    .v_x(basis_vecs[3]), .v_y(basis_vecs[4]), .v_z(basis_vecs[5]),
    .w_x(basis_vecs[6]), .w_y(basis_vecs[7]), .w_z(basis_vecs[8]),
    .first_zero(first_zero), .second_replaced(second_replaced),
    .third_replaced(third_replaced),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gso_basis_checker chk (
    .clk(clk), .rst(rst), .vec_valid(vec_valid), .vec_ready(vec_ready),
    .vec_word(vec_word), .basis_valid(basis_valid), .basis_ready(basis_ready),
    .basis_vecs(basis_vecs), .first_zero(first_zero),
    .second_replaced(second_replaced), .third_replaced(third_replaced),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  initial forever #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("gram_schmidt_orthonormalize_3d regression: fail");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 700;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        basis_ready <= 0;
      end else begin
        basis_ready <= quiet || ($urandom_range(99) >= 37);
      end
    end
  end

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_word(logic [8:0][31:0] wd);
    if (!quiet && $urandom_range(99) < 37) begin
      vec_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    vec_valid <= 1;
    vec_word <= wd;
    do @(posedge clk); while (!vec_ready);
  endtask

  task automatic drain();
    vec_valid <= 0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [8:0][31:0] mk(logic [31:0] ax, ay, az, bx, by, bz,
                                         cx, cy, cz);
    return {cz, cy, cx, bz, by, bx, az, ay, ax};
  endfunction

  function automatic logic [31:0] rnd_small();
    logic [31:0] x;
    x = $urandom >> $urandom_range(7, 31);
    return $urandom_range(1) ? -x : x;
  endfunction

  function automatic logic [8:0][31:0] rnd_word();
    logic [8:0][31:0] wd;
    int k, p, q;
    k = $urandom_range(99);
    if (k < 30) begin
      for (int i = 0; i < 9; i++) wd[i] = $urandom;
    end else if (k < 55) begin
      for (int i = 0; i < 9; i++) wd[i] = rnd_small();
    end else if (k < 85) begin
      // b near a multiple of a, c near the span of a and b
      p = $urandom_range(0, 8) - 4;
      q = $urandom_range(0, 8) - 4;
      for (int i = 0; i < 3; i++) begin
        wd[i] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        wd[3 + i] = wd[i] * p + ($urandom_range(1) ? $urandom_range(0, 6) - 3 : 0);
        wd[6 + i] = wd[i] * q + wd[3 + i] * p +
                    ($urandom_range(1) ? $urandom_range(0, 6) - 3 : 0);
      end
    end else if (k < 95) begin
      for (int i = 0; i < 3; i++) wd[i] = $urandom_range(0, 4) - 2;
      for (int i = 3; i < 9; i++) wd[i] = $urandom;
    end else begin
      for (int i = 0; i < 3; i++) wd[i] = 0;
      for (int i = 3; i < 9; i++) wd[i] = $urandom;
    end
    return wd;
  endfunction

  task automatic directed_words();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    // zero first vector
    send_word(mk(0, 0, 0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    send_word(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // b parallel to a, x dominant and then y dominant fallback
    send_word(mk(ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 3 * ONE));
    send_word(mk(0, ONE, 0, 0, -ONE, 0, ONE, 0, 0));
    send_word(mk(ONE, ONE, 0, 3 * ONE, 3 * ONE, 0, 0, 0, ONE));
    send_word(mk(0, 0, ONE, 0, 0, 5 * ONE, 0, ONE, 0));
    // c in the span of a and b
    send_word(mk(ONE, 0, 0, 0, ONE, 0, 5 * ONE, -2 * ONE, 0));
    // both residuals exactly zero
    send_word(mk(ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(-ONE, 0, 0, 7 * ONE, 0, 0, -ONE, 0, 0));
    // extremes
    send_word(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_word(mk(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_word(mk(mn, 0, 0, mx, mn, mx, mn, mx, mn));
    send_word(mk(mx, mn, mx, mn, mx, mn, mx, mn, mx));
    send_word(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_word(mk(-1, 1, -1, mx, 0, mn, 1, -1, 0));
    send_word(mk(0, mn, 1, mx, 0, 0, 0, mx, 0));
    send_word(mk(3, -2, 1, 6, -4, 2, 1, 1, 1));
    send_word(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1, 1, 32'hFFFF_FFFF, 0, 1));
  endtask

  initial begin
    logic [31:0] thr_set [5];
    thr_set[0] = {1'b0, THR_RESET};
    thr_set[1] = 32'd0;
    thr_set[2] = 32'hFFFF_FFFF;
    thr_set[3] = 32'd1073741824;
    thr_set[4] = $urandom_range(0, 1 << 20);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) apb_write(ADDR_THR, thr_set[ph]);
      // an out-of-range write must leave the threshold alone
      if (ph == 3) apb_write(ADDR_SPARE, $urandom);
      if (ph < 2) directed_words();
      for (int n = 0; n < 90; n++) begin
        if (ph == 2 && n == 20) hold_req = 1;
        quiet = (ph == 3 && n >= 10 && n < 80);
        send_word(rnd_word());
      end
      quiet = 0;
      drain();
    end

    repeat (300) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("gram_schmidt_orthonormalize_3d regression: pass");
    else
      $display("gram_schmidt_orthonormalize_3d regression: fail");
    $finish;
  end

endmodule
